// File: design/aowa_pkg.sv
// Shared constants, types and arctangent table for the Ackermann outer-angle pipeline.
package aowa_pkg;

   localparam int ANGLE_WIDTH     = 16;
   localparam int CORDIC_STAGES   = 16;
   localparam int FRAC_SHIFT      = 32 - ANGLE_WIDTH;
   localparam int LEN_WIDTH       = 16;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int MAG_WIDTH       = 32;
   localparam int ROT_WIDTH       = MAG_WIDTH + 1;
   localparam int POS_WIDTH       = 31;
   localparam int PROD_WIDTH      = LEN_WIDTH + POS_WIDTH;
   localparam int VEC_WIDTH       = PROD_WIDTH + 4;
   localparam int ATAN_WIDTH      = 30;
   localparam int ATAN_LEN        = 32;
   localparam int ROUND_SHIFT     = (FRAC_SHIFT > 0) ? FRAC_SHIFT - 1 : 0;

   typedef logic signed [ANGLE_WIDTH-1:0] angle_type;
   typedef logic signed [ROT_WIDTH-1:0]   rot_type;
   typedef logic signed [VEC_WIDTH-1:0]   vec_type;
   typedef logic [LEN_WIDTH-1:0]          len_type;
   typedef logic [POS_WIDTH-1:0]          pos_type;
   typedef logic [MAG_WIDTH-1:0]          mag_type;
   typedef logic [PROD_WIDTH-1:0]         prod_type;
   typedef logic [CSR_INDEX_WIDTH-1:0]    csr_index_type;

   typedef struct packed {
      logic neg;
      logic zero;
   } ctl_type;

   localparam mag_type HALF_PI_Q30 = 32'd1686629713;
   localparam mag_type ROUND_BIAS  = (FRAC_SHIFT > 0) ? (MAG_WIDTH'(1) << ROUND_SHIFT) : '0;
   localparam rot_type X_INIT      = ROT_WIDTH'(1) << 30;

   localparam len_type WHEELBASE_RESET = 16'd768;
   localparam len_type TRACK_RESET     = 16'd384;

   localparam csr_index_type CSR_WHEELBASE = 4'd0;
   localparam csr_index_type CSR_TRACK     = 4'd1;

   localparam logic [ATAN_WIDTH-1:0] ATAN_Q30 [ATAN_LEN] = '{
      30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
      30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
      30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
      30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
      30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
      30'd32,        30'd16,        30'd8,         30'd4,         30'd2,
      30'd1,         30'd0
   };

endpackage

// File: design/aowa_cordic_rot.sv
// Pipelined CORDIC rotation of (1,0) by a Q30 angle, one stage per iteration.
module aowa_cordic_rot (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  aowa_pkg::ctl_type in_ctl,
   input  aowa_pkg::rot_type in_z,
   output logic              out_valid,
   output aowa_pkg::ctl_type out_ctl,
   output aowa_pkg::rot_type out_x,
   output aowa_pkg::rot_type out_y
);

   localparam int N = aowa_pkg::CORDIC_STAGES;

   logic              valid_ff  [N];
   aowa_pkg::ctl_type ctl_ff    [N];
   aowa_pkg::rot_type x_ff      [N];
   aowa_pkg::rot_type y_ff      [N];
   aowa_pkg::rot_type z_ff      [N];
   logic              valid_src [N];
   aowa_pkg::ctl_type ctl_src   [N];
   aowa_pkg::rot_type x_src     [N];
   aowa_pkg::rot_type y_src     [N];
   aowa_pkg::rot_type z_src     [N];
   aowa_pkg::rot_type x_in      [N];
   aowa_pkg::rot_type y_in      [N];
   aowa_pkg::rot_type z_in      [N];

   always_comb begin
      valid_src[0] = in_valid;
      ctl_src[0]   = in_ctl;
      x_src[0]     = aowa_pkg::X_INIT;
      y_src[0]     = '0;
      z_src[0]     = in_z;
      for (int k = 1; k < N; k++) begin
         valid_src[k] = valid_ff[k-1];
         ctl_src[k]   = ctl_ff[k-1];
         x_src[k]     = x_ff[k-1];
         y_src[k]     = y_ff[k-1];
         z_src[k]     = z_ff[k-1];
      end
   end

   // rotate toward zero residual angle
   always_comb begin
      for (int k = 0; k < N; k++) begin
         if (!z_src[k][aowa_pkg::ROT_WIDTH-1]) begin
            x_in[k] = x_src[k] - (y_src[k] >>> k);
            y_in[k] = y_src[k] + (x_src[k] >>> k);
            z_in[k] = z_src[k] - aowa_pkg::rot_type'(aowa_pkg::ATAN_Q30[k]);
         end else begin
            x_in[k] = x_src[k] + (y_src[k] >>> k);
            y_in[k] = y_src[k] - (x_src[k] >>> k);
            z_in[k] = z_src[k] + aowa_pkg::rot_type'(aowa_pkg::ATAN_Q30[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < N; k++) valid_ff[k] <= valid_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            ctl_ff[k] <= ctl_src[k];
            x_ff[k]   <= x_in[k];
            y_ff[k]   <= y_in[k];
            z_ff[k]   <= z_in[k];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_ctl   = ctl_ff[N-1];
   assign out_x     = x_ff[N-1];
   assign out_y     = y_ff[N-1];

endmodule

// File: design/aowa_cordic_vec.sv
// Pipelined CORDIC vectoring: accumulates atan2(q, p) as a Q30 angle.
module aowa_cordic_vec (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  aowa_pkg::ctl_type in_ctl,
   input  aowa_pkg::vec_type in_p,
   input  aowa_pkg::vec_type in_q,
   output logic              out_valid,
   output aowa_pkg::ctl_type out_ctl,
   output aowa_pkg::rot_type out_r
);

   localparam int N = aowa_pkg::CORDIC_STAGES;

   logic              valid_ff  [N];
   aowa_pkg::ctl_type ctl_ff    [N];
   aowa_pkg::vec_type p_ff      [N];
   aowa_pkg::vec_type q_ff      [N];
   aowa_pkg::rot_type r_ff      [N];
   logic              valid_src [N];
   aowa_pkg::ctl_type ctl_src   [N];
   aowa_pkg::vec_type p_src     [N];
   aowa_pkg::vec_type q_src     [N];
   aowa_pkg::rot_type r_src     [N];
   aowa_pkg::vec_type p_in      [N];
   aowa_pkg::vec_type q_in      [N];
   aowa_pkg::rot_type r_in      [N];

   always_comb begin
      valid_src[0] = in_valid;
      ctl_src[0]   = in_ctl;
      p_src[0]     = in_p;
      q_src[0]     = in_q;
      r_src[0]     = '0;
      for (int k = 1; k < N; k++) begin
         valid_src[k] = valid_ff[k-1];
         ctl_src[k]   = ctl_ff[k-1];
         p_src[k]     = p_ff[k-1];
         q_src[k]     = q_ff[k-1];
         r_src[k]     = r_ff[k-1];
      end
   end

   // drive q toward zero, summing the angle turned
   always_comb begin
      for (int k = 0; k < N; k++) begin
         if (!q_src[k][aowa_pkg::VEC_WIDTH-1]) begin
            p_in[k] = p_src[k] + (q_src[k] >>> k);
            q_in[k] = q_src[k] - (p_src[k] >>> k);
            r_in[k] = r_src[k] + aowa_pkg::rot_type'(aowa_pkg::ATAN_Q30[k]);
         end else begin
            p_in[k] = p_src[k] - (q_src[k] >>> k);
            q_in[k] = q_src[k] + (p_src[k] >>> k);
            r_in[k] = r_src[k] - aowa_pkg::rot_type'(aowa_pkg::ATAN_Q30[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < N; k++) valid_ff[k] <= valid_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            ctl_ff[k] <= ctl_src[k];
            p_ff[k]   <= p_in[k];
            q_ff[k]   <= q_in[k];
            r_ff[k]   <= r_in[k];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_ctl   = ctl_ff[N-1];
   assign out_r     = r_ff[N-1];

endmodule

// File: design/ackermann_outer_wheel_angle.sv
// Ackermann outer-wheel steer angle: top level with config registers and pipeline control.
//
// Request channel (req_valid, req_stall, req_inner_angle): one signed Q2.14 radian
// inner-wheel angle per item. Response channel (rsp_valid, rsp_stall, rsp_outer_angle):
// one signed Q2.14 outer-wheel angle per item, in request order.
// Config channel (csr_valid, csr_ready, csr_index, csr_wdata): index 0 is the wheelbase,
// index 1 the track width, both unsigned Q8.8; other indexes are dropped. csr_ready is
// always high. Write config only while no item is in flight.
// Pipeline stages: an input register, the rotation CORDIC stages, a multiply stage,
// an add stage, the vectoring CORDIC stages and the output register. Throughput is
// one item per cycle while req_stall is low; every CORDIC iteration has its own
// register stage.
// Reset clears all valid bits and loads wheelbase 3.0 and track 1.5.
// When the receiver stalls, the response holds; the pipeline keeps moving and taking
// requests until an item reaches the last stage, then req_stall rises until the
// response is taken.
module ackermann_outer_wheel_angle (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  aowa_pkg::angle_type     req_inner_angle,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output aowa_pkg::angle_type     rsp_outer_angle,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  aowa_pkg::csr_index_type csr_index,
   input  aowa_pkg::len_type       csr_wdata
);

   localparam int AW = aowa_pkg::ANGLE_WIDTH;
   localparam aowa_pkg::angle_type MAX_OUT =
      AW'((aowa_pkg::HALF_PI_Q30 + aowa_pkg::ROUND_BIAS) >> aowa_pkg::FRAC_SHIFT);

   aowa_pkg::len_type   wheelbase_ff;
   aowa_pkg::len_type   track_ff;

   logic                pipe_en;
   logic                out_load;

   logic [AW-1:0]       raw_bits;
   logic [AW-1:0]       mag_abs;
   aowa_pkg::mag_type   mag_wide;
   aowa_pkg::mag_type   mag_clamp;
   aowa_pkg::ctl_type   s0_ctl_in;
   logic                s0_valid_ff;
   aowa_pkg::ctl_type   s0_ctl_ff;
   aowa_pkg::rot_type   s0_z_ff;

   logic                rot_valid;
   aowa_pkg::ctl_type   rot_ctl;
   aowa_pkg::rot_type   rot_x;
   aowa_pkg::rot_type   rot_y;
   aowa_pkg::pos_type   x_pos;
   aowa_pkg::pos_type   y_pos;

   aowa_pkg::prod_type  lx_in;
   aowa_pkg::prod_type  wy_in;
   aowa_pkg::prod_type  ly_in;
   logic                mul_valid_ff;
   aowa_pkg::ctl_type   mul_ctl_ff;
   aowa_pkg::prod_type  lx_ff;
   aowa_pkg::prod_type  wy_ff;
   aowa_pkg::prod_type  ly_ff;

   aowa_pkg::ctl_type   add_ctl_in;
   logic                add_valid_ff;
   aowa_pkg::ctl_type   add_ctl_ff;
   aowa_pkg::vec_type   p_ff;
   aowa_pkg::vec_type   q_ff;

   logic                vec_valid;
   aowa_pkg::ctl_type   vec_ctl;
   aowa_pkg::rot_type   vec_r;

   aowa_pkg::mag_type   r_clamp;
   aowa_pkg::mag_type   round_sum;
   aowa_pkg::mag_type   round_shift;
   logic [AW-1:0]       mag_out;
   aowa_pkg::angle_type outer_in;
   logic                rsp_valid_ff;
   aowa_pkg::angle_type rsp_outer_angle_ff;

   // config registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wheelbase_ff <= aowa_pkg::WHEELBASE_RESET;
         track_ff     <= aowa_pkg::TRACK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            aowa_pkg::CSR_WHEELBASE: wheelbase_ff <= csr_wdata;
            aowa_pkg::CSR_TRACK:     track_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // freeze only when the last stage holds an item and the output slot cannot take it
   assign pipe_en   = !(vec_valid && rsp_valid_ff && rsp_stall);
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !pipe_en;

   // input stage: magnitude, Q30 scale, clamp to pi/2
   always_comb begin
      raw_bits       = req_inner_angle;
      mag_abs        = raw_bits[AW-1] ? (~raw_bits + AW'(1)) : raw_bits;
      mag_wide       = aowa_pkg::MAG_WIDTH'(mag_abs) << aowa_pkg::FRAC_SHIFT;
      mag_clamp      = (mag_wide > aowa_pkg::HALF_PI_Q30) ? aowa_pkg::HALF_PI_Q30 : mag_wide;
      s0_ctl_in.neg  = raw_bits[AW-1];
      s0_ctl_in.zero = (raw_bits == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s0_ctl_ff <= s0_ctl_in;
         s0_z_ff   <= aowa_pkg::rot_type'(mag_clamp);
      end
   end

   aowa_cordic_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (s0_valid_ff),
      .in_ctl    (s0_ctl_ff),
      .in_z      (s0_z_ff),
      .out_valid (rot_valid),
      .out_ctl   (rot_ctl),
      .out_x     (rot_x),
      .out_y     (rot_y)
   );

   // drop small negative residue, then form L*cos, W*sin, L*sin
   assign x_pos = rot_x[aowa_pkg::ROT_WIDTH-1] ? '0 : rot_x[aowa_pkg::POS_WIDTH-1:0];
   assign y_pos = rot_y[aowa_pkg::ROT_WIDTH-1] ? '0 : rot_y[aowa_pkg::POS_WIDTH-1:0];
   assign lx_in = wheelbase_ff * x_pos;
   assign wy_in = track_ff * y_pos;
   assign ly_in = wheelbase_ff * y_pos;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         mul_valid_ff <= rot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mul_ctl_ff <= rot_ctl;
         lx_ff      <= lx_in;
         wy_ff      <= wy_in;
         ly_ff      <= ly_in;
      end
   end

   always_comb begin
      add_ctl_in      = mul_ctl_ff;
      add_ctl_in.zero = mul_ctl_ff.zero || (ly_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         add_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         add_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         add_ctl_ff <= add_ctl_in;
         p_ff       <= aowa_pkg::vec_type'(lx_ff) + aowa_pkg::vec_type'(wy_ff);
         q_ff       <= aowa_pkg::vec_type'(ly_ff);
      end
   end

   aowa_cordic_vec u_vec (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (add_valid_ff),
      .in_ctl    (add_ctl_ff),
      .in_p      (p_ff),
      .in_q      (q_ff),
      .out_valid (vec_valid),
      .out_ctl   (vec_ctl),
      .out_r     (vec_r)
   );

   // output stage: clamp to 0..pi/2, round half up, restore sign, force zero when flagged
   always_comb begin
      if (vec_r[aowa_pkg::ROT_WIDTH-1]) begin
         r_clamp = '0;
      end else if (vec_r[aowa_pkg::MAG_WIDTH-1:0] > aowa_pkg::HALF_PI_Q30) begin
         r_clamp = aowa_pkg::HALF_PI_Q30;
      end else begin
         r_clamp = vec_r[aowa_pkg::MAG_WIDTH-1:0];
      end
      round_sum   = r_clamp + aowa_pkg::ROUND_BIAS;
      round_shift = round_sum >> aowa_pkg::FRAC_SHIFT;
      mag_out     = round_shift[AW-1:0];
      if (vec_ctl.zero) begin
         outer_in = '0;
      end else if (vec_ctl.neg) begin
         outer_in = ~mag_out + AW'(1);
      end else begin
         outer_in = mag_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= vec_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_outer_angle_ff <= outer_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outer_angle = rsp_outer_angle_ff;

   // requests back up only behind a stalled, full output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled response");

   a_out_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_outer_angle <= MAX_OUT) && (rsp_outer_angle >= -MAX_OUT)))
      else $error("outer angle beyond pi/2");

   a_wheelbase_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index == aowa_pkg::CSR_WHEELBASE))
      |=> (wheelbase_ff == $past(csr_wdata)))
      else $error("wheelbase write lost");

   a_track_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index == aowa_pkg::CSR_TRACK))
      |=> (track_ff == $past(csr_wdata)))
      else $error("track width write lost");

endmodule
